// ===== hdl/sdec_pkg.sv =====
package sdec_pkg;

  // longest text is a sign and ten digits
  localparam int unsigned DIGITS_MAX = 10;
  localparam int unsigned CNT_W      = $clog2(DIGITS_MAX + 1);

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_MINUS = 8'd45;

  // x / 10 == (x * ceil(2^35 / 10)) >> 35 for every 32-bit unsigned x
  localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
  localparam int unsigned RECIP_SHIFT = 35;

  typedef logic [3:0]       digit_t;
  typedef logic [CNT_W-1:0] count_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_EMIT
  } state_t;

endpackage

// ===== hdl/signed_int_to_decimal_ascii_core.sv =====
// signed 32-bit integer to decimal ascii, one character per out_valid beat
// the first character comes once start is taken and all n digits are divided out, n = 1..10
// an item emits 1..11 characters; a new start is taken only in idle, after its last one,
//   paced by the single shared divide-by-ten unit and the one-beat-per-cycle output
// reset: synchronous active-low rst_n returns the sequencer to idle, no beat pending
// the receiver cannot stall: each beat is shown for exactly one cycle
module signed_int_to_decimal_ascii_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  output logic [7:0]         out_char_code,
  output logic               out_is_last
);

  sdec_pkg::state_t state_r, state_nxt;

  // magnitude being reduced, one digit per divide cycle
  logic [31:0]      mag_r, mag_nxt;
  // digits held so far in divide, digits left to send in emit
  sdec_pkg::count_t nd_r, nd_nxt;
  // sign character still owed
  logic             sign_r, sign_nxt;

  // digit store, least significant digit at index 0
  sdec_pkg::digit_t digit_r [sdec_pkg::DIGITS_MAX];

  logic [31:0]      div_quot;
  sdec_pkg::digit_t div_rem;
  sdec_pkg::count_t rd_idx;
  logic             in_neg;
  logic             take;
  logic             div_done;

  // shared divide-by-ten unit, one digit per cycle
  sdec_div10 u_div10 (
    .dividend  (mag_r),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  assign take     = start && !busy;
  assign in_neg   = in_value[31];
  assign rd_idx   = nd_r - sdec_pkg::count_t'(1);
  // stop on zero quotient or when the store is full
  assign div_done = (div_quot == 32'd0) ||
                    (nd_r == sdec_pkg::count_t'(sdec_pkg::DIGITS_MAX - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sdec_pkg::ST_IDLE: begin
        if (take) state_nxt = sdec_pkg::ST_DIVIDE;
      end
      sdec_pkg::ST_DIVIDE: begin
        if (div_done) state_nxt = sdec_pkg::ST_EMIT;
      end
      sdec_pkg::ST_EMIT: begin
        if (!sign_r && nd_r == sdec_pkg::count_t'(1)) state_nxt = sdec_pkg::ST_IDLE;
      end
      default: state_nxt = sdec_pkg::ST_IDLE;
    endcase
  end

  // datapath next values
  always_comb begin
    mag_nxt  = mag_r;
    nd_nxt   = nd_r;
    sign_nxt = sign_r;
    case (state_r)
      sdec_pkg::ST_IDLE: begin
        if (take) begin
          // unsigned negate also covers the most negative value
          mag_nxt  = in_neg ? (32'd0 - 32'(unsigned'(in_value))) : 32'(unsigned'(in_value));
          nd_nxt   = '0;
          sign_nxt = in_neg;
        end
      end
      sdec_pkg::ST_DIVIDE: begin
        mag_nxt = div_quot;
        nd_nxt  = nd_r + sdec_pkg::count_t'(1);
      end
      sdec_pkg::ST_EMIT: begin
        if (sign_r) begin
          sign_nxt = 1'b0;
        end else begin
          nd_nxt = nd_r - sdec_pkg::count_t'(1);
        end
      end
      default: begin
        nd_nxt = '0;
      end
    endcase
  end

  // outputs
  always_comb begin
    busy          = 1'b1;
    out_valid     = 1'b0;
    out_char_code = sdec_pkg::CHAR_ZERO;
    out_is_last   = 1'b0;
    case (state_r)
      sdec_pkg::ST_IDLE: begin
        busy = 1'b0;
      end
      sdec_pkg::ST_DIVIDE: begin
        busy = 1'b1;
      end
      sdec_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (sign_r) begin
          // at least one digit always follows the sign
          out_char_code = sdec_pkg::CHAR_MINUS;
        end else begin
          out_char_code = sdec_pkg::CHAR_ZERO + {4'd0, digit_r[rd_idx]};
          out_is_last   = (nd_r == sdec_pkg::count_t'(1));
        end
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sdec_pkg::ST_IDLE;
      nd_r    <= '0;
      sign_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      nd_r    <= nd_nxt;
      sign_r  <= sign_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    if (state_r == sdec_pkg::ST_DIVIDE) begin
      digit_r[nd_r] <= div_rem;
    end
  end

  a_take_starts_divide: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> state_r == sdec_pkg::ST_DIVIDE)
    else $error("accepted item did not start dividing");

  a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_last |=> !out_valid && !busy)
    else $error("beat after last character");

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sdec_pkg::ST_DIVIDE |-> div_rem < 4'd10 &&
      nd_r < sdec_pkg::count_t'(sdec_pkg::DIGITS_MAX))
    else $error("divide step out of range");

  a_emit_has_digits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sdec_pkg::ST_EMIT |-> nd_r != '0)
    else $error("emit with empty digit store");

  a_char_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_char_code == sdec_pkg::CHAR_MINUS ||
      (out_char_code >= sdec_pkg::CHAR_ZERO && out_char_code <= 8'd57))
    else $error("bad character code");

endmodule

// ===== hdl/sdec_div10.sv =====
module sdec_div10 (
  input  logic [31:0]     dividend,
  output logic [31:0]     quotient,
  output sdec_pkg::digit_t remainder
);

  logic [63:0]       product;
  sdec_pkg::digit_t  q_times_ten;

  assign product  = {32'd0, dividend} * {32'd0, sdec_pkg::RECIP_10};
  assign quotient = 32'(product >> sdec_pkg::RECIP_SHIFT);

  // remainder is below ten, so the low nibble of q*10 is all that matters
  assign q_times_ten = {quotient[0], 3'b000} + {quotient[2:0], 1'b0};
  assign remainder   = dividend[3:0] - q_times_ten;

endmodule
